[src/radix_digit_converter_macros.svh]
// ----------------------------------------------------------------------------
// Radix digit converter assertion macros
// Concurrent check wrappers. They expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef RADIX_DIGIT_CONVERTER_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define RDC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequent must hold in the same cycle as the antecedent
`define RDC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define RDC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define RDC_ASSERT(label, clk, rst, prop, msg)
`define RDC_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define RDC_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif

`endif

[src/rdc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdc_pkg
// Shared types, constants and helpers of the radix digit converter.
// ----------------------------------------------------------------------------
package rdc_pkg;

   localparam int VALUE_W       = 31;
   localparam int BASE_W        = 6;
   localparam int DIGIT_W       = 6;
   localparam int CHAR_W        = 7;
   localparam int RDC_MAX_DIGITS = 32;
   // most digits a 31-bit value can have (base two)
   localparam int RESULT_LIMIT  = 31;

   localparam logic [BASE_W-1:0]  BASE_MIN   = 6'd2;
   localparam logic [BASE_W-1:0]  BASE_MAX   = 6'd36;
   localparam logic [DIGIT_W-1:0] DIGIT_TEN  = 6'd10;
   localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
   localparam logic [CHAR_W-1:0]  ASCII_NINE = 7'd57;
   localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
   localparam logic [CHAR_W-1:0]  ASCII_Z    = 7'd90;

   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_out_type;

   typedef struct packed {
      logic               start;
      logic [VALUE_W-1:0] dividend;
      logic [BASE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [VALUE_W-1:0] quotient;
      logic [DIGIT_W-1:0] remainder;
   } div_rsp_type;

   function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
      logic [CHAR_W-1:0] ch;
      if (d >= DIGIT_TEN) begin
         ch = ASCII_A + CHAR_W'(d - DIGIT_TEN);
      end else begin
         ch = ASCII_ZERO + CHAR_W'(d);
      end
      return ch;
   endfunction

endpackage

[src/rdc_front.sv]
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"
// ----------------------------------------------------------------------------
// rdc_front
// Accepts requests, clamps the base into 2..36 and holds them in a
// two-entry queue for the conversion engine.
// ----------------------------------------------------------------------------
module rdc_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [rdc_pkg::VALUE_W-1:0] req_value,
   input  logic [rdc_pkg::BASE_W-1:0]  req_base,
   output rdc_pkg::queue_out_type     q_out,
   input  logic                       q_pop
);
   import rdc_pkg::*;

   localparam int QDEPTH = 2;

   item_type          entry_ff [QDEPTH];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;
   logic              push;
   logic              pop;
   item_type          classified;

   always_comb begin
      classified.value = req_value;
      if (req_base < BASE_MIN) begin
         classified.base = BASE_MIN;
      end else if (req_base > BASE_MAX) begin
         classified.base = BASE_MAX;
      end else begin
         classified.base = req_base;
      end
   end

   assign req_ready   = (count_ff != 2'(QDEPTH));
   assign push        = req_valid && req_ready;
   assign pop         = q_pop && (count_ff != 2'd0);
   assign q_out.valid = (count_ff != 2'd0);
   assign q_out.item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= classified;
      end
   end

   `RDC_ASSERT(a_q_count_range, clock, reset, count_ff <= 2'(QDEPTH), "queue count overflow")

endmodule

[src/rdc_div.sv]
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"
// ----------------------------------------------------------------------------
// rdc_div
// Restoring divider, one quotient bit per cycle: 31-bit value by the base.
// ----------------------------------------------------------------------------
module rdc_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rdc_pkg::div_req_type  div_req,
   output rdc_pkg::div_rsp_type  div_rsp
);
   import rdc_pkg::*;

   localparam int STEP_W = $clog2(VALUE_W);

   logic [VALUE_W-1:0] q_ff;
   logic [DIGIT_W:0]   rem_ff;
   logic [BASE_W-1:0]  div_ff;
   logic [STEP_W-1:0]  step_ff;
   logic               busy_ff;
   logic               done_ff;
   logic [DIGIT_W:0]   rem_shift;
   logic               ge;

   // remainder stays below the divisor, so the shifted value fits in 7 bits
   assign rem_shift = {rem_ff[DIGIT_W-1:0], q_ff[VALUE_W-1]};
   assign ge        = (rem_shift >= {1'b0, div_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_req.start) begin
            busy_ff <= 1'b1;
            step_ff <= '0;
         end else if (busy_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         q_ff   <= div_req.dividend;
         rem_ff <= '0;
         div_ff <= div_req.divisor;
      end else if (busy_ff) begin
         q_ff   <= {q_ff[VALUE_W-2:0], ge};
         rem_ff <= ge ? (rem_shift - {1'b0, div_ff}) : rem_shift;
      end
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = q_ff;
   assign div_rsp.remainder = rem_ff[DIGIT_W-1:0];

   `RDC_ASSERT_IMP(a_rem_below_div, clock, reset, done_ff, rem_ff < {1'b0, div_ff}, "remainder not below divisor")

endmodule

[src/rdc_back.sv]
`timescale 1ns / 1ps
`include "radix_digit_converter_macros.svh"
// ----------------------------------------------------------------------------
// rdc_back
// Conversion engine: collects digits least significant first into the
// digit store, then replays them most significant first to the output.
// ----------------------------------------------------------------------------
module rdc_back #(
   parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  rdc_pkg::queue_out_type      q_out,
   output logic                        q_pop,
   output rdc_pkg::div_req_type        div_req,
   input  rdc_pkg::div_rsp_type        div_rsp,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rdc_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                        rsp_last
);
   import rdc_pkg::*;

   localparam int CAP   = (MAX_DIGITS < RESULT_LIMIT) ? MAX_DIGITS : RESULT_LIMIT;
   localparam int IDX_W = $clog2(CAP);

   typedef enum logic [4:0] {
      ST_IDLE      = 5'b00001,
      ST_DIV_START = 5'b00010,
      ST_DIV_WAIT  = 5'b00100,
      ST_FETCH     = 5'b01000,
      ST_EMIT      = 5'b10000
   } back_state_type;

   back_state_type     state_ff, state_in;
   logic [VALUE_W-1:0] remaining_ff, remaining_in;
   logic [BASE_W-1:0]  base_ff, base_in;
   logic [IDX_W-1:0]   wr_idx_ff, wr_idx_in;
   logic [IDX_W-1:0]   ptr_ff, ptr_in;
   logic [DIGIT_W-1:0] digit_store [CAP];
   logic [DIGIT_W-1:0] rd_data_ff;
   logic               store_wr;
   logic               out_load;
   logic               emit;
   logic               rsp_valid_ff;
   logic [CHAR_W-1:0]  rsp_digit_char_ff;
   logic               rsp_last_ff;

   assign out_load = !rsp_valid_ff || rsp_ready;
   assign emit     = (state_ff == ST_EMIT) && out_load;
   assign q_pop    = (state_ff == ST_IDLE) && q_out.valid;
   assign store_wr = (state_ff == ST_DIV_WAIT) && div_rsp.done;

   assign div_req.start    = (state_ff == ST_DIV_START);
   assign div_req.dividend = remaining_ff;
   assign div_req.divisor  = base_ff;

   always_comb begin
      state_in     = state_ff;
      remaining_in = remaining_ff;
      base_in      = base_ff;
      wr_idx_in    = wr_idx_ff;
      ptr_in       = ptr_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_out.valid) begin
               remaining_in = q_out.item.value;
               base_in      = q_out.item.base;
               wr_idx_in    = '0;
               state_in     = ST_DIV_START;
            end
         end
         ST_DIV_START: begin
            state_in = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               remaining_in = div_rsp.quotient;
               // a zero value still yields its single '0' digit here
               if (div_rsp.quotient == '0 || wr_idx_ff == IDX_W'(CAP - 1)) begin
                  ptr_in   = wr_idx_ff;
                  state_in = ST_FETCH;
               end else begin
                  wr_idx_in = wr_idx_ff + 1'b1;
                  state_in  = ST_DIV_START;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_load) begin
               if (ptr_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  ptr_in   = ptr_ff - 1'b1;
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         remaining_ff <= '0;
         wr_idx_ff    <= '0;
         ptr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         remaining_ff <= remaining_in;
         wr_idx_ff    <= wr_idx_in;
         ptr_ff       <= ptr_in;
         if (out_load) begin
            rsp_valid_ff <= emit;
         end
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      if (emit) begin
         rsp_digit_char_ff <= digit_to_ascii(rd_data_ff);
         rsp_last_ff       <= (ptr_ff == '0);
      end
   end

   // digit store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_wr) begin
         digit_store[wr_idx_ff] <= div_rsp.remainder;
      end
      rd_data_ff <= digit_store[ptr_ff];
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_digit_char = rsp_digit_char_ff;
   assign rsp_last       = rsp_last_ff;

   `RDC_ASSERT(a_char_legal, clock, reset, !rsp_valid_ff || (rsp_digit_char_ff >= ASCII_ZERO && rsp_digit_char_ff <= ASCII_NINE) || (rsp_digit_char_ff >= ASCII_A && rsp_digit_char_ff <= ASCII_Z), "illegal digit character")
   `RDC_ASSERT_IMP(a_done_in_wait, clock, reset, div_rsp.done, state_ff == ST_DIV_WAIT, "divider result outside wait state")
   `RDC_ASSERT_NXT(a_last_ends_item, clock, reset, emit && ptr_ff == '0, state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff, "final digit did not close the item")

endmodule

[src/radix_digit_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radix_digit_converter
// Converts a 31-bit unsigned value to ASCII digits in base 2..36.
// ----------------------------------------------------------------------------
// Each request (value, base) yields one response per digit, most significant
// first, '0'-'9' then 'A'-'Z', with rsp_last on the least significant digit;
// zero gives a single '0'. Bases below 2 act as 2, above 36 as 36. A two-entry
// request queue lets new requests be taken while one is converted. Items are
// converted one at a time: for each digit the bit-serial divider is started,
// computes the quotient bit by bit and the remainder is written back to the
// digit store; then each digit is fetched from the digit store and replayed.
// ----------------------------------------------------------------------------
module radix_digit_converter #(
   parameter int MAX_DIGITS = rdc_pkg::RDC_MAX_DIGITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [rdc_pkg::VALUE_W-1:0] req_value,
   input  logic [rdc_pkg::BASE_W-1:0]  req_base,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [rdc_pkg::CHAR_W-1:0]  rsp_digit_char,
   output logic                        rsp_last
);
   import rdc_pkg::*;

   queue_out_type q_out;
   logic          q_pop;
   div_req_type   div_req;
   div_rsp_type   div_rsp;

   rdc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_value (req_value),
      .req_base  (req_base),
      .q_out     (q_out),
      .q_pop     (q_pop)
   );

   rdc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   rdc_back #(
      .MAX_DIGITS (MAX_DIGITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_out          (q_out),
      .q_pop          (q_pop),
      .div_req        (div_req),
      .div_rsp        (div_rsp),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for radix_digit_converter.
// A table of corner values and bases runs first and is drained in full.
// Random numbers in random bases follow, with random stalls on both sides
// and one long receiver hold-off. Each digit transfer is checked in order
// against the table's golden string or a predictor of repeated division.
// ----------------------------------------------------------------------------
module testbench;
   import rdc_pkg::*;

   localparam int DIRECTED_N  = 25;
   localparam int RANDOM_N    = 300;
   localparam int HOLD_CYCLES = 3000;
   localparam int END_WAIT    = 1200;
   localparam int CYCLE_LIMIT = 3000000;
   localparam int DIGIT_CAP   = (RDC_MAX_DIGITS < RESULT_LIMIT) ? RDC_MAX_DIGITS
                                                                : RESULT_LIMIT;

   typedef struct packed {
      logic [CHAR_W-1:0] ch;
      logic              last;
   } digit_type;

   typedef struct {
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
      string              golden;   // empty: use the predictor
   } vector_type;

   logic               clock     = 1'b0;
   logic               reset     = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [VALUE_W-1:0] req_value = '0;
   logic [BASE_W-1:0]  req_base  = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [CHAR_W-1:0]  rsp_digit_char;
   logic               rsp_last;

   digit_type pending_digits[$];
   int     error_count     = 0;
   int     items_sent      = 0;
   int     saturated_items = 0;
   int     digits_checked  = 0;
   int     longest_number  = 0;
   int     cycle_count     = 0;
   int     tx_busy         = 0;
   int     rx_busy         = 0;
   bit     hold_off_req    = 1'b0;

   vector_type directed_table [DIRECTED_N] = '{
      '{31'd0,          6'd10, "0"},
      '{31'd0,          6'd0,  "0"},
      '{31'd0,          6'd63, "0"},
      '{31'd1,          6'd2,  "1"},
      '{31'd2147483647, 6'd2,  ""},
      '{31'd2147483647, 6'd8,  "17777777777"},
      '{31'd2147483647, 6'd10, "2147483647"},
      '{31'd2147483647, 6'd16, "7FFFFFFF"},
      '{31'd2147483647, 6'd36, "ZIK0ZJ"},
      '{31'd35,         6'd36, "Z"},
      '{31'd35,         6'd63, "Z"},
      '{31'd36,         6'd37, "10"},
      '{31'd5,          6'd1,  "101"},
      '{31'd2,          6'd0,  "10"},
      '{31'd9,          6'd10, "9"},
      '{31'd10,         6'd11, "A"},
      '{31'd255,        6'd16, "FF"},
      '{31'd1295,       6'd36, "ZZ"},
      '{31'd1073741824, 6'd2,  ""},
      '{31'd1073741823, 6'd2,  ""},
      '{31'd123456789,  6'd7,  ""},
      '{31'd1162261467, 6'd3,  ""},
      '{31'd60466175,   6'd36, "ZZZZZ"},
      '{31'd1,          6'd36, "1"},
      '{31'd100,        6'd10, "100"}
   };

   radix_digit_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_value      (req_value),
      .req_base       (req_base),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_digit_char (rsp_digit_char),
      .rsp_last       (rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // mostly no gap, some short ones, a few long ones; level 0 never idles
   function automatic int pick_gap(input int level);
      int roll;
      roll = $urandom_range(0, 99);
      if (level == 0 || roll < 100 - 20 * level) return 0;
      if (roll < 97) return $urandom_range(1, 4);
      return $urandom_range(8, 60);
   endfunction

   // digits by repeated division, queued most significant first
   function automatic void convert_to_digits(input logic [VALUE_W-1:0] value,
                                             input logic [BASE_W-1:0]  base);
      logic [DIGIT_W-1:0] digits [DIGIT_CAP];
      logic [VALUE_W-1:0] rest;
      logic [BASE_W-1:0]  radix;
      logic [DIGIT_W-1:0] d;
      logic [CHAR_W-1:0]  ch;
      int                 n;
      int                 i;
      radix = (base < BASE_MIN) ? BASE_MIN : (base > BASE_MAX) ? BASE_MAX : base;
      rest  = value;
      n     = 0;
      if (rest == '0) begin
         pending_digits.push_back('{ch: ASCII_ZERO, last: 1'b1});
         return;
      end
      while (rest != '0 && n < DIGIT_CAP) begin
         digits[n] = DIGIT_W'(rest % radix);
         rest      = rest / radix;
         n++;
      end
      if (n > longest_number) longest_number = n;
      for (i = n - 1; i >= 0; i--) begin
         d  = digits[i];
         ch = (d >= DIGIT_TEN) ? ASCII_A + CHAR_W'(d - DIGIT_TEN)
                               : ASCII_ZERO + CHAR_W'(d);
         pending_digits.push_back('{ch: ch, last: (i == 0)});
      end
   endfunction

   task automatic offer_item(input logic [VALUE_W-1:0] value,
                             input logic [BASE_W-1:0]  base,
                             input string              golden);
      int gap;
      int i;
      req_valid <= 1'b1;
      req_value <= value;
      req_base  <= base;
      do @(posedge clock); while (!req_ready);
      if (golden.len() == 0) begin
         convert_to_digits(value, base);
      end else begin
         for (i = 0; i < golden.len(); i++)
            pending_digits.push_back('{ch: CHAR_W'(golden[i]), last: (i == golden.len() - 1)});
         if (golden.len() > longest_number) longest_number = golden.len();
      end
      items_sent++;
      if (base < BASE_MIN || base > BASE_MAX) saturated_items++;
      gap = pick_gap(tx_busy);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_for_drain();
      do @(posedge clock); while (pending_digits.size() != 0);
   endtask

   initial begin : stimulus
      logic [VALUE_W-1:0] value;
      logic [BASE_W-1:0]  base;
      longint             power;
      int                 radix;
      int                 pick;
      int                 k;
      int                 i;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < DIRECTED_N; i++)
         offer_item(directed_table[i].value, directed_table[i].base, directed_table[i].golden);

      // sender stays quiet until every digit so far has come out
      req_valid <= 1'b0;
      wait_for_drain();

      for (i = 0; i < RANDOM_N; i++) begin
         if (i % 20 == 0) tx_busy = $urandom_range(0, 2);
         // receiver holds off while the sender keeps pushing back to back
         if (i == 100) begin
            hold_off_req = 1'b1;
            tx_busy      = 0;
         end
         case ($urandom_range(0, 9))
            8:       base = BASE_W'($urandom_range(0, 1));
            9:       base = BASE_W'($urandom_range(37, 63));
            default: base = BASE_W'($urandom_range(2, 36));
         endcase
         radix = (base < BASE_MIN) ? BASE_MIN : (base > BASE_MAX) ? BASE_MAX : base;
         pick  = $urandom_range(0, 9);
         if (pick < 4) begin
            value = VALUE_W'($urandom());
         end else if (pick < 7) begin
            value = VALUE_W'($urandom() >> $urandom_range(1, 31));
         end else if (pick == 7) begin
            case ($urandom_range(0, 2))
               0:       value = '0;
               1:       value = VALUE_W'(1);
               default: value = '1;
            endcase
         end else begin
            // a power of the base, or one below it: digit count rolls over here
            power = 1;
            k     = $urandom_range(1, 30);
            repeat (k) if (power * radix <= 64'h7FFF_FFFF) power = power * radix;
            value = VALUE_W'(power - $urandom_range(0, 1));
         end
         offer_item(value, base, "");
      end

      req_valid <= 1'b0;
      wait_for_drain();
      repeat (END_WAIT) @(posedge clock);

      $display("Converted %0d numbers (%0d with out-of-range bases) into %0d digits,",
               items_sent, saturated_items, digits_checked);
      $display("longest %0d; receiver held off %0d cycles once, sender waited out a drain.",
               longest_number, HOLD_CYCLES);
      if (error_count == 0 && pending_digits.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   initial begin : rsp_side
      int stall;
      int phase_left;
      stall      = 0;
      phase_left = 0;
      while (reset) @(posedge clock);
      forever begin
         if (phase_left == 0) begin
            rx_busy    = $urandom_range(0, 2);
            phase_left = 400;
         end
         phase_left--;
         if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall        = HOLD_CYCLES;
         end else if (stall == 0) begin
            stall = pick_gap(rx_busy);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
         @(posedge clock);
      end
   end

   always @(posedge clock) begin : digit_check
      digit_type head;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_digits.size() == 0) begin
            $display("%0t: unexpected digit transfer, char %0d last %0b",
                     $time, rsp_digit_char, rsp_last);
            error_count++;
         end else begin
            head = pending_digits.pop_front();
            digits_checked++;
            if (rsp_digit_char !== head.ch) begin
               $display("%0t: digit_char expected %0d ('%c') got %0d ('%c')",
                        $time, head.ch, head.ch, rsp_digit_char, rsp_digit_char);
               error_count++;
            end
            if (rsp_last !== head.last) begin
               $display("%0t: last expected %0b got %0b", $time, head.last, rsp_last);
               error_count++;
            end
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("%0t: timed out after %0d cycles, %0d digits still pending",
               $time, cycle_count, pending_digits.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

[sim.f]
+incdir+src
src/rdc_pkg.sv
src/rdc_front.sv
src/rdc_div.sv
src/rdc_back.sv
src/radix_digit_converter.sv
dv/testbench.sv
